[hw/rtl/gcf_pkg.sv]
// Shared types, constants and command/status structs for the glyph contour flattener.
package gcf_pkg;

	localparam int CoordW     = 34;
	localparam int NW         = 5;
	localparam int ArcW       = 40;
	localparam int DistW      = 33;
	localparam int CntW       = 7;
	localparam int MaxResults = 64;
	localparam int WW         = 11;
	localparam int AccW       = 48;
	localparam int DivW       = 47;
	localparam int RemW       = 11;
	localparam int SqW        = 64;
	localparam int RadW       = 66;
	localparam int SrRemW     = 37;
	localparam int InW        = 16;
	localparam int OutW       = 32;

	localparam logic [1:0] CFG_SUBSAMPLE = 2'd0;
	localparam logic [1:0] CFG_LINE_SUB  = 2'd1;
	localparam logic [1:0] CFG_SCALE_X   = 2'd2;
	localparam logic [1:0] CFG_SCALE_Y   = 2'd3;

	typedef logic signed [CoordW-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} vec_t;

	typedef enum logic [1:0] {
		PH_WAIT,
		PH_CTL,
		PH_RUN0,
		PH_RUN
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCALE,
		ST_MAIN,
		ST_LAST,
		ST_LA,
		ST_LB,
		ST_END,
		ST_FLUSH,
		ST_SEG_A,
		ST_EMIT,
		ST_DWAIT,
		ST_PUSH,
		ST_NEXT,
		ST_CWAIT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_P0,
		OP_P1_ON,
		OP_P1_OFF,
		OP_RUN_ON,
		OP_RUN_MID,
		OP_RUN_CTL,
		OP_LFIX,
		OP_LA_FON,
		OP_LA_MID,
		OP_LB,
		OP_END
	} op_t;

	typedef struct packed {
		logic          in_load;
		logic          scale;
		op_t           op;
		logic          samp_a;
		logic          dist_start;
		logic          calc_start;
		logic [NW-1:0] calc_s;
		logic          push;
		logic          emit_first;
		logic          flush;
	} cmd_t;

	typedef struct packed {
		logic          in_on;
		logic          in_last;
		logic          ctl_pend;
		logic          first_on;
		logic          seg_sub;
		logic [NW-1:0] n;
		logic          dist_done;
		logic          calc_done;
		logic          dist_busy;
		logic          calc_busy;
		logic          hold_valid;
		logic          out_free;
	} status_t;

endpackage

[hw/rtl/gcf_ctrl.sv]
// Controller state machine: contour phase tracking and segment/sample sequencing.
module gcf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  gcf_pkg::status_t  st,
	output gcf_pkg::cmd_t     cmd
);

	gcf_pkg::state_t state_q, state_d, ret_q, ret_d;
	gcf_pkg::phase_t phase_q, phase_d;
	logic [gcf_pkg::NW-1:0]   s_q, s_d;
	logic [gcf_pkg::CntW-1:0] cnt_q, cnt_d;
	gcf_pkg::state_t after_main;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gcf_pkg::ST_IDLE;
			ret_q   <= gcf_pkg::ST_IDLE;
			phase_q <= gcf_pkg::PH_WAIT;
			s_q     <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			phase_q <= phase_d;
			s_q     <= s_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		ret_d      = ret_q;
		phase_d    = phase_q;
		s_d        = s_q;
		cnt_d      = cnt_q;
		cmd        = '0;
		cmd.op     = gcf_pkg::OP_NONE;
		in_ready   = 1'b0;
		after_main = st.in_last ? gcf_pkg::ST_LAST : gcf_pkg::ST_FLUSH;
		unique case (state_q)
			gcf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.in_load = 1'b1;
					cnt_d       = '0;
					state_d     = gcf_pkg::ST_SCALE;
				end
			end
			gcf_pkg::ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = gcf_pkg::ST_MAIN;
			end
			gcf_pkg::ST_MAIN: begin
				priority if (phase_q == gcf_pkg::PH_WAIT) begin
					cmd.op  = gcf_pkg::OP_P0;
					phase_d = st.in_on ? gcf_pkg::PH_RUN0 : gcf_pkg::PH_CTL;
					state_d = after_main;
				end else if (phase_q == gcf_pkg::PH_CTL) begin
					cmd.op  = st.in_on ? gcf_pkg::OP_P1_ON : gcf_pkg::OP_P1_OFF;
					phase_d = gcf_pkg::PH_RUN0;
					state_d = after_main;
				end else if (st.in_on) begin
					cmd.op  = gcf_pkg::OP_RUN_ON;
					s_d     = '0;
					ret_d   = after_main;
					state_d = gcf_pkg::ST_SEG_A;
				end else if (st.ctl_pend) begin
					cmd.op  = gcf_pkg::OP_RUN_MID;
					s_d     = '0;
					ret_d   = after_main;
					state_d = gcf_pkg::ST_SEG_A;
				end else begin
					cmd.op  = gcf_pkg::OP_RUN_CTL;
					state_d = after_main;
				end
			end
			gcf_pkg::ST_LAST: begin
				if (phase_q == gcf_pkg::PH_CTL) begin
					cmd.op  = gcf_pkg::OP_LFIX;
					phase_d = gcf_pkg::PH_RUN0;
				end
				state_d = gcf_pkg::ST_LA;
			end
			gcf_pkg::ST_LA: begin
				priority if (st.first_on) begin
					cmd.op  = gcf_pkg::OP_LA_FON;
					s_d     = '0;
					ret_d   = gcf_pkg::ST_END;
					state_d = gcf_pkg::ST_SEG_A;
				end else if (st.ctl_pend) begin
					cmd.op  = gcf_pkg::OP_LA_MID;
					s_d     = '0;
					ret_d   = gcf_pkg::ST_LB;
					state_d = gcf_pkg::ST_SEG_A;
				end else begin
					state_d = gcf_pkg::ST_LB;
				end
			end
			gcf_pkg::ST_LB: begin
				cmd.op  = gcf_pkg::OP_LB;
				s_d     = '0;
				ret_d   = gcf_pkg::ST_END;
				state_d = gcf_pkg::ST_SEG_A;
			end
			gcf_pkg::ST_END: begin
				cmd.op  = gcf_pkg::OP_END;
				phase_d = gcf_pkg::PH_WAIT;
				state_d = gcf_pkg::ST_FLUSH;
			end
			gcf_pkg::ST_FLUSH: begin
				priority if (!st.hold_valid) begin
					state_d = gcf_pkg::ST_IDLE;
				end else if (st.out_free) begin
					cmd.flush = 1'b1;
					state_d   = gcf_pkg::ST_IDLE;
				end else begin
					state_d = gcf_pkg::ST_FLUSH;
				end
			end
			gcf_pkg::ST_SEG_A: begin
				cmd.samp_a = 1'b1;
				state_d    = gcf_pkg::ST_EMIT;
			end
			gcf_pkg::ST_EMIT: begin
				priority if (cnt_q >= gcf_pkg::CntW'(gcf_pkg::MaxResults)) begin
					state_d = gcf_pkg::ST_NEXT;
				end else if (phase_q == gcf_pkg::PH_RUN) begin
					cmd.dist_start = 1'b1;
					state_d        = gcf_pkg::ST_DWAIT;
				end else begin
					state_d = gcf_pkg::ST_PUSH;
				end
			end
			gcf_pkg::ST_DWAIT: begin
				if (st.dist_done) state_d = gcf_pkg::ST_PUSH;
			end
			gcf_pkg::ST_PUSH: begin
				if (!st.hold_valid || st.out_free) begin
					cmd.push       = 1'b1;
					cmd.emit_first = (phase_q != gcf_pkg::PH_RUN);
					phase_d        = gcf_pkg::PH_RUN;
					cnt_d          = cnt_q + gcf_pkg::CntW'(1);
					state_d        = gcf_pkg::ST_NEXT;
				end
			end
			gcf_pkg::ST_NEXT: begin
				if (st.seg_sub && (({1'b0, s_q} + 6'd1) < {1'b0, st.n})) begin
					s_d            = s_q + gcf_pkg::NW'(1);
					cmd.calc_start = 1'b1;
					cmd.calc_s     = s_q + gcf_pkg::NW'(1);
					state_d        = gcf_pkg::ST_CWAIT;
				end else begin
					state_d = ret_q;
				end
			end
			gcf_pkg::ST_CWAIT: begin
				if (st.calc_done) state_d = gcf_pkg::ST_EMIT;
			end
			default: state_d = gcf_pkg::ST_IDLE;
		endcase
	end

endmodule

[hw/rtl/gcf_dp.sv]
// Datapath: config registers, contour state, sample and distance units, output staging.
module gcf_dp #(
	parameter int SUBSAMPLE_MAX = 16,
	parameter int FRAC_BITS     = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [15:0]                         cfg_data,
	input  logic signed [gcf_pkg::InW-1:0]      in_x,
	input  logic signed [gcf_pkg::InW-1:0]      in_y,
	input  logic                                in_on,
	input  logic                                in_last,
	input  gcf_pkg::cmd_t                       cmd,
	output gcf_pkg::status_t                    st,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [gcf_pkg::OutW-1:0]     out_x,
	output logic signed [gcf_pkg::OutW-1:0]     out_y,
	output logic [gcf_pkg::ArcW-1:0]            out_arc,
	output logic                                out_run_last,
	output logic                                out_done
);

	localparam int NCap = (SUBSAMPLE_MAX > 31) ? 31 : SUBSAMPLE_MAX;

	function automatic gcf_pkg::coord_t scale16(logic signed [gcf_pkg::InW-1:0] v,
	                                            logic [15:0] s);
		logic signed [32:0] pr;
		pr = v * $signed({1'b0, s});
		return gcf_pkg::CoordW'(pr);
	endfunction

	function automatic gcf_pkg::coord_t mid1(gcf_pkg::coord_t a, gcf_pkg::coord_t b);
		logic signed [gcf_pkg::CoordW:0] sm;
		sm = {a[gcf_pkg::CoordW-1], a} + {b[gcf_pkg::CoordW-1], b} + 1'sb1 + 1'sb1 + 1'sb1;
		sm = {a[gcf_pkg::CoordW-1], a} + {b[gcf_pkg::CoordW-1], b} + (gcf_pkg::CoordW+1)'(1);
		return gcf_pkg::CoordW'(sm >>> 1);
	endfunction

	// config
	logic [gcf_pkg::NW-1:0] sub_cnt_q, n;
	logic                   line_sub_q;
	logic [15:0]            scale_x_q, scale_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_cnt_q  <= gcf_pkg::NW'(8);
			line_sub_q <= 1'b0;
			scale_x_q  <= 16'(1 << FRAC_BITS);
			scale_y_q  <= 16'(1 << FRAC_BITS);
		end else if (cfg_we) begin
			unique case (cfg_index)
				gcf_pkg::CFG_SUBSAMPLE: sub_cnt_q  <= cfg_data[gcf_pkg::NW-1:0];
				gcf_pkg::CFG_LINE_SUB:  line_sub_q <= cfg_data[0];
				gcf_pkg::CFG_SCALE_X:   scale_x_q  <= cfg_data;
				gcf_pkg::CFG_SCALE_Y:   scale_y_q  <= cfg_data;
			endcase
		end
	end

	always_comb begin
		if (sub_cnt_q == '0) n = gcf_pkg::NW'(1);
		else if (sub_cnt_q > gcf_pkg::NW'(NCap)) n = gcf_pkg::NW'(NCap);
		else n = sub_cnt_q;
	end

	// input beat and contour state
	logic signed [gcf_pkg::InW-1:0] in_x_q, in_y_q, first_x_q, first_y_q;
	logic                           in_on_q, in_last_q, first_on_q, ctl_pend_q, seg_quad_q;
	gcf_pkg::vec_t p_q, f_q, sa_q, ss_q, pc_q, seg_a_q, seg_c_q, seg_b_q, samp_q, prev_q;
	gcf_pkg::vec_t mid_a, mid_b, m;
	logic [gcf_pkg::ArcW-1:0] dist_sum_q, new_dist;
	logic [gcf_pkg::ArcW:0]   dist_add;
	logic [gcf_pkg::DistW-1:0] d_q;

	always_comb begin
		mid_a = (cmd.op == gcf_pkg::OP_P1_OFF) ? f_q : pc_q;
		mid_b = (cmd.op == gcf_pkg::OP_LA_MID) ? f_q : p_q;
		m.x   = mid1(mid_a.x, mid_b.x);
		m.y   = mid1(mid_a.y, mid_b.y);
	end

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			in_x_q    <= in_x;
			in_y_q    <= in_y;
			in_on_q   <= in_on;
			in_last_q <= in_last;
		end
		if (cmd.scale) begin
			p_q.x <= scale16(in_x_q, scale_x_q);
			p_q.y <= scale16(in_y_q, scale_y_q);
			f_q.x <= scale16(first_x_q, scale_x_q);
			f_q.y <= scale16(first_y_q, scale_y_q);
		end
		unique case (cmd.op)
			gcf_pkg::OP_NONE, gcf_pkg::OP_END: begin
			end
			gcf_pkg::OP_P0: begin
				first_x_q <= in_x_q;
				first_y_q <= in_y_q;
				f_q       <= p_q;
				if (in_on_q) begin
					sa_q <= p_q;
					ss_q <= p_q;
				end
			end
			gcf_pkg::OP_P1_ON: begin
				sa_q <= p_q;
				ss_q <= p_q;
			end
			gcf_pkg::OP_P1_OFF: begin
				sa_q <= m;
				ss_q <= m;
				pc_q <= p_q;
			end
			gcf_pkg::OP_RUN_ON: begin
				seg_a_q    <= ss_q;
				seg_c_q    <= pc_q;
				seg_b_q    <= p_q;
				seg_quad_q <= ctl_pend_q;
				ss_q       <= p_q;
			end
			gcf_pkg::OP_RUN_MID: begin
				seg_a_q    <= ss_q;
				seg_c_q    <= pc_q;
				seg_b_q    <= m;
				seg_quad_q <= 1'b1;
				ss_q       <= m;
				pc_q       <= p_q;
			end
			gcf_pkg::OP_RUN_CTL: pc_q <= p_q;
			gcf_pkg::OP_LFIX: begin
				sa_q <= f_q;
				ss_q <= f_q;
			end
			gcf_pkg::OP_LA_FON: begin
				seg_a_q    <= ss_q;
				seg_c_q    <= pc_q;
				seg_b_q    <= sa_q;
				seg_quad_q <= ctl_pend_q;
			end
			gcf_pkg::OP_LA_MID: begin
				seg_a_q    <= ss_q;
				seg_c_q    <= pc_q;
				seg_b_q    <= m;
				seg_quad_q <= 1'b1;
				ss_q       <= m;
			end
			gcf_pkg::OP_LB: begin
				seg_a_q    <= ss_q;
				seg_c_q    <= f_q;
				seg_b_q    <= sa_q;
				seg_quad_q <= 1'b1;
			end
			default: begin
			end
		endcase
		if (cmd.push) prev_q <= samp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_on_q <= 1'b0;
			ctl_pend_q <= 1'b0;
			dist_sum_q <= '0;
		end else begin
			unique case (cmd.op)
				gcf_pkg::OP_P0: begin
					first_on_q <= in_on_q;
					ctl_pend_q <= 1'b0;
				end
				gcf_pkg::OP_P1_ON, gcf_pkg::OP_RUN_ON,
				gcf_pkg::OP_LFIX, gcf_pkg::OP_END: ctl_pend_q <= 1'b0;
				gcf_pkg::OP_P1_OFF, gcf_pkg::OP_RUN_CTL: ctl_pend_q <= 1'b1;
				default: begin
				end
			endcase
			if (cmd.op == gcf_pkg::OP_P0 || cmd.op == gcf_pkg::OP_END) dist_sum_q <= '0;
			else if (cmd.push) dist_sum_q <= new_dist;
		end
	end

	always_comb begin
		dist_add = {1'b0, dist_sum_q} + (gcf_pkg::ArcW+1)'(d_q);
		if (cmd.emit_first) new_dist = '0;
		else if (dist_add[gcf_pkg::ArcW]) new_dist = '1;
		else new_dist = dist_add[gcf_pkg::ArcW-1:0];
	end

	// sample unit: three-term MAC then restoring divide, x then y
	logic                    c_busy_q, c_coord_q, c_div_q, c_done_q;
	logic [5:0]              c_cnt_q;
	logic [gcf_pkg::WW-1:0]  wa_q, wc_q, wb_q, den_q, den2_q;
	logic [gcf_pkg::WW-1:0]  uu, su, sq, u_ext, s_ext;
	logic [gcf_pkg::NW-1:0]  u;
	logic signed [gcf_pkg::AccW-1:0] acc_q, prod;
	logic [gcf_pkg::DivW-1:0] q_q;
	logic [gcf_pkg::RemW-1:0] r_q;
	logic [gcf_pkg::RemW:0]   trial, rdiff;
	logic [49:0]              nb;
	gcf_pkg::coord_t          coef;
	logic [gcf_pkg::WW-1:0]   w;

	always_comb begin
		u     = n - cmd.calc_s;
		u_ext = gcf_pkg::WW'(u);
		s_ext = gcf_pkg::WW'(cmd.calc_s);
		uu    = u_ext * u_ext;
		su    = u_ext * s_ext;
		sq    = s_ext * s_ext;
		unique case (c_cnt_q[1:0])
			2'd0: begin
				coef = c_coord_q ? seg_a_q.y : seg_a_q.x;
				w    = wa_q;
			end
			2'd1: begin
				coef = c_coord_q ? seg_c_q.y : seg_c_q.x;
				w    = wc_q;
			end
			default: begin
				coef = c_coord_q ? seg_b_q.y : seg_b_q.x;
				w    = wb_q;
			end
		endcase
		prod  = coef * $signed({1'b0, w});
		nb    = ({{2{acc_q[gcf_pkg::AccW-1]}}, acc_q} << 1) + 50'(den_q)
		      + (50'(den2_q) << gcf_pkg::CoordW);
		trial = {r_q, q_q[gcf_pkg::DivW-1]};
		rdiff = trial - {1'b0, den2_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.calc_start) begin
			if (seg_quad_q) begin
				wa_q   <= uu;
				wc_q   <= su << 1;
				wb_q   <= sq;
				den_q  <= gcf_pkg::WW'(n) * gcf_pkg::WW'(n);
				den2_q <= (gcf_pkg::WW'(n) * gcf_pkg::WW'(n)) << 1;
			end else begin
				wa_q   <= u_ext;
				wc_q   <= '0;
				wb_q   <= s_ext;
				den_q  <= gcf_pkg::WW'(n);
				den2_q <= gcf_pkg::WW'(n) << 1;
			end
			acc_q <= '0;
		end else if (c_busy_q && !c_div_q) begin
			if (c_cnt_q == 6'd3) begin
				q_q <= nb[gcf_pkg::DivW-1:0];
				r_q <= '0;
			end else begin
				acc_q <= acc_q + prod;
			end
		end else if (c_busy_q && c_div_q) begin
			if (!rdiff[gcf_pkg::RemW]) begin
				r_q <= rdiff[gcf_pkg::RemW-1:0];
				q_q <= {q_q[gcf_pkg::DivW-2:0], 1'b1};
			end else begin
				r_q <= trial[gcf_pkg::RemW-1:0];
				q_q <= {q_q[gcf_pkg::DivW-2:0], 1'b0};
			end
			if (c_cnt_q == 6'(gcf_pkg::DivW - 1)) acc_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_busy_q  <= 1'b0;
			c_coord_q <= 1'b0;
			c_div_q   <= 1'b0;
			c_cnt_q   <= '0;
			c_done_q  <= 1'b0;
		end else begin
			c_done_q <= 1'b0;
			if (cmd.calc_start) begin
				c_busy_q  <= 1'b1;
				c_coord_q <= 1'b0;
				c_div_q   <= 1'b0;
				c_cnt_q   <= '0;
			end else if (c_busy_q && !c_div_q) begin
				if (c_cnt_q == 6'd3) begin
					c_div_q <= 1'b1;
					c_cnt_q <= '0;
				end else begin
					c_cnt_q <= c_cnt_q + 6'd1;
				end
			end else if (c_busy_q) begin
				if (c_cnt_q == 6'(gcf_pkg::DivW - 1)) begin
					c_cnt_q <= '0;
					c_div_q <= 1'b0;
					if (c_coord_q) begin
						c_busy_q <= 1'b0;
						c_done_q <= 1'b1;
					end else begin
						c_coord_q <= 1'b1;
					end
				end else begin
					c_cnt_q <= c_cnt_q + 6'd1;
				end
			end
		end
	end

	// current sample: segment start or divider result
	logic [gcf_pkg::DivW-1:0] q_fin;
	assign q_fin = {q_q[gcf_pkg::DivW-2:0], ~rdiff[gcf_pkg::RemW]};

	always_ff @(posedge clk) begin
		if (cmd.samp_a) samp_q <= seg_a_q;
		else if (c_busy_q && c_div_q && c_cnt_q == 6'(gcf_pkg::DivW - 1)) begin
			if (c_coord_q) samp_q.y <= q_fin[gcf_pkg::CoordW-1:0];
			else samp_q.x <= q_fin[gcf_pkg::CoordW-1:0];
		end
	end

	// distance unit: shift-add squares mod 2^64, then bit-pair square root
	logic                      d_busy_q, d_done_q;
	logic [1:0]                d_mode_q;
	logic [5:0]                d_cnt_q;
	logic [gcf_pkg::SqW-1:0]   mx_q, my_q, sx_q, sy_q;
	logic [gcf_pkg::CoordW-1:0] qx_q, qy_q, ux, uy;
	logic signed [gcf_pkg::CoordW:0] dx, dy;
	logic [gcf_pkg::RadW-1:0]  rad_q;
	logic [gcf_pkg::SrRemW-1:0] rem_q, rem2, strial, sdiff;
	logic [gcf_pkg::DistW-1:0] root_q, root_n;
	logic [gcf_pkg::SqW:0]     ssum;

	always_comb begin
		dx     = {samp_q.x[gcf_pkg::CoordW-1], samp_q.x} - {prev_q.x[gcf_pkg::CoordW-1], prev_q.x};
		dy     = {samp_q.y[gcf_pkg::CoordW-1], samp_q.y} - {prev_q.y[gcf_pkg::CoordW-1], prev_q.y};
		ux     = dx[gcf_pkg::CoordW] ? gcf_pkg::CoordW'(-dx) : gcf_pkg::CoordW'(dx);
		uy     = dy[gcf_pkg::CoordW] ? gcf_pkg::CoordW'(-dy) : gcf_pkg::CoordW'(dy);
		ssum   = {1'b0, sx_q} + {1'b0, sy_q};
		rem2   = {rem_q[gcf_pkg::SrRemW-3:0], rad_q[gcf_pkg::RadW-1 -: 2]};
		strial = gcf_pkg::SrRemW'({root_q, 2'b01});
		sdiff  = rem2 - strial;
		root_n = (rem2 >= strial) ? {root_q[gcf_pkg::DistW-2:0], 1'b1}
		                          : {root_q[gcf_pkg::DistW-2:0], 1'b0};
	end

	always_ff @(posedge clk) begin
		if (cmd.dist_start) begin
			mx_q <= gcf_pkg::SqW'(ux);
			my_q <= gcf_pkg::SqW'(uy);
			qx_q <= ux;
			qy_q <= uy;
			sx_q <= '0;
			sy_q <= '0;
		end else if (d_busy_q) begin
			unique case (d_mode_q)
				2'd0: begin
					if (qx_q[0]) sx_q <= sx_q + mx_q;
					if (qy_q[0]) sy_q <= sy_q + my_q;
					mx_q <= mx_q << 1;
					my_q <= my_q << 1;
					qx_q <= qx_q >> 1;
					qy_q <= qy_q >> 1;
				end
				2'd1: begin
					rad_q  <= gcf_pkg::RadW'(ssum);
					rem_q  <= '0;
					root_q <= '0;
				end
				default: begin
					rem_q  <= (rem2 >= strial) ? sdiff : rem2;
					root_q <= root_n;
					rad_q  <= rad_q << 2;
					if (d_cnt_q == 6'(gcf_pkg::DistW - 1)) d_q <= root_n;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_busy_q <= 1'b0;
			d_done_q <= 1'b0;
			d_mode_q <= '0;
			d_cnt_q  <= '0;
		end else begin
			d_done_q <= 1'b0;
			if (cmd.dist_start) begin
				d_busy_q <= 1'b1;
				d_mode_q <= 2'd0;
				d_cnt_q  <= '0;
			end else if (d_busy_q) begin
				unique case (d_mode_q)
					2'd0: begin
						if (d_cnt_q == 6'(gcf_pkg::CoordW - 1)) begin
							d_mode_q <= 2'd1;
							d_cnt_q  <= '0;
						end else begin
							d_cnt_q <= d_cnt_q + 6'd1;
						end
					end
					2'd1: d_mode_q <= 2'd2;
					default: begin
						if (d_cnt_q == 6'(gcf_pkg::DistW - 1)) begin
							d_busy_q <= 1'b0;
							d_done_q <= 1'b1;
							d_mode_q <= 2'd0;
							d_cnt_q  <= '0;
						end else begin
							d_cnt_q <= d_cnt_q + 6'd1;
						end
					end
				endcase
			end
		end
	end

	// one-deep hold so the final beat of a step can be tagged
	logic                            hold_v_q, out_v_q;
	logic signed [gcf_pkg::OutW-1:0] hold_x_q, hold_y_q, out_x_q, out_y_q;
	logic [gcf_pkg::ArcW-1:0]        hold_arc_q, out_arc_q;
	logic                            out_last_q, out_done_q, out_free;

	assign out_free = !out_v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_v_q && out_ready) out_v_q <= 1'b0;
			if ((cmd.push && hold_v_q) || cmd.flush) out_v_q <= 1'b1;
			if (cmd.push) hold_v_q <= 1'b1;
			else if (cmd.flush) hold_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((cmd.push && hold_v_q) || cmd.flush) begin
			out_x_q    <= hold_x_q;
			out_y_q    <= hold_y_q;
			out_arc_q  <= hold_arc_q;
			out_last_q <= cmd.flush;
			out_done_q <= cmd.flush && in_last_q;
		end
		if (cmd.push) begin
			hold_x_q   <= samp_q.x[gcf_pkg::OutW-1:0];
			hold_y_q   <= samp_q.y[gcf_pkg::OutW-1:0];
			hold_arc_q <= new_dist;
		end
	end

	assign out_valid    = out_v_q;
	assign out_x        = out_x_q;
	assign out_y        = out_y_q;
	assign out_arc      = out_arc_q;
	assign out_run_last = out_last_q;
	assign out_done     = out_done_q;

	always_comb begin
		st            = '0;
		st.in_on      = in_on_q;
		st.in_last    = in_last_q;
		st.ctl_pend   = ctl_pend_q;
		st.first_on   = first_on_q;
		st.seg_sub    = seg_quad_q | line_sub_q;
		st.n          = n;
		st.dist_done  = d_done_q;
		st.calc_done  = c_done_q;
		st.dist_busy  = d_busy_q;
		st.calc_busy  = c_busy_q;
		st.hold_valid = hold_v_q;
		st.out_free   = out_free;
	end

endmodule

[hw/rtl/glyph_contour_flattener_top.sv]
// Glyph contour flattener top level: stream ports, controller and datapath.
// Each point is loaded and scaled first; then per result a curve sample takes two
// 47-step divides plus a distance (34-step squares, 33-step root);
// segment start points skip the divide. Points are taken one at a time.
// Reset (arst_n low, asynchronous) clears the contour state and restores the registers
// to subsample 8, no line subdivision and unity scale.
module glyph_contour_flattener_top #(
	parameter int SUBSAMPLE_MAX = 16,
	parameter int FRAC_BITS     = 12
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [31:0]  s_axis_tdata,   // point_x[15:0], point_y[31:16]
	input  logic         s_axis_tuser,   // on_curve
	input  logic         s_axis_tlast,   // last_point
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [103:0] m_axis_tdata,   // out_x[31:0], out_y[63:32], arc_length[103:64]
	output logic         m_axis_tuser,   // contour_done
	output logic         m_axis_tlast,   // run_last
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	gcf_pkg::cmd_t    cmd;
	gcf_pkg::status_t st;
	logic signed [gcf_pkg::OutW-1:0] ox, oy;
	logic [gcf_pkg::ArcW-1:0]        oarc;

	gcf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	gcf_dp #(
		.SUBSAMPLE_MAX (SUBSAMPLE_MAX),
		.FRAC_BITS     (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_x         (s_axis_tdata[15:0]),
		.in_y         (s_axis_tdata[31:16]),
		.in_on        (s_axis_tuser),
		.in_last      (s_axis_tlast),
		.cmd          (cmd),
		.st           (st),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_x        (ox),
		.out_y        (oy),
		.out_arc      (oarc),
		.out_run_last (m_axis_tlast),
		.out_done     (m_axis_tuser)
	);

	assign m_axis_tdata = {oarc, oy, ox};

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(st.calc_busy && st.dist_busy))
		else $error("sample and distance units busy together");

	a_hold_flushed: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !st.hold_valid)
		else $error("input ready while a beat is still held");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
		else $error("contour_done beat without run_last");

endmodule
